### rtl/fkvt_pkg.sv
// Package for the fixed-capacity key/value table.
// Holds default sizes, field widths, operation codes, state codes and the cell command.
// No dependencies.
package fkvt_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KIND_BITS  = 3;
  localparam int RANK_BITS  = 6;
  localparam int COUNT_BITS = 7;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_UPSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_LOOKUP = 3'd4,
    KIND_RANK   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_DEC  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // What the row of cells does in the apply cycle.
  typedef struct packed {
    logic upd;  // matching cell takes the new value
    logic ins;  // cells above the new key shift up, new pair enters
    logic ers;  // matching cell and those above take their upper neighbor
  } cell_cmd_t;

endpackage

### rtl/fkvt_in_if.sv
// Operation channel of the key/value table: valid/ready plus one operation.
// Depends on fkvt_pkg for field widths.
interface fkvt_in_if
  import fkvt_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] new_value;
  logic [RANK_BITS-1:0]  rank_index;

  modport source (output valid, kind, key, new_value, rank_index, input ready);
  modport sink   (input valid, kind, key, new_value, rank_index, output ready);
endinterface

### rtl/fkvt_out_if.sv
// Result channel of the key/value table: valid/ready plus one result.
// Depends on fkvt_pkg for field widths.
interface fkvt_out_if
  import fkvt_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [KEY_BITS-1:0]   key_out;
  logic [VALUE_BITS-1:0] value_out;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  is_empty;

  modport source (output valid, ok, key_out, value_out, entry_count, is_empty, input ready);
  modport sink   (input valid, ok, key_out, value_out, entry_count, is_empty, output ready);
endinterface

### rtl/fkvt_cell.sv
// One slot of the sorted key/value row: holds a pair, compares it to the
// operation key and shifts to or from its neighbors. Depends on fkvt_pkg.
module fkvt_cell
  import fkvt_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  cmp_en,
  input  logic                  occupied,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic                  prev_gt,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  gt,
  output logic                  eq
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  gt_r;
  logic                  eq_r;

  // An empty slot counts as greater than any key, so the flags along the
  // row always read 0..0 1..1.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      gt_r <= !occupied || (key_r > cmp_key);
      eq_r <= occupied && (key_r == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && eq_r) begin
      val_r <= new_value;
    end else if (cmd.ins && gt_r) begin
      if (prev_gt) begin
        key_r <= prev_key;
        val_r <= prev_value;
      end else begin
        key_r <= cmp_key;
        val_r <= new_value;
      end
    end else if (cmd.ers && (gt_r || eq_r)) begin
      key_r <= next_key;
      val_r <= next_value;
    end
  end

  assign key   = key_r;
  assign value = val_r;
  assign gt    = gt_r;
  assign eq    = eq_r;

endmodule

### rtl/fixed_capacity_key_value_table_unit.sv
// Channel   Dir  Payload                                           Transfer
// in_ch     in   kind, key, new_value, rank_index                  valid && ready
// out_ch    out  ok, key_out, value_out, entry_count, is_empty     valid && ready
//
// Each operation passes through four steps: accept, compare in every cell, decide, apply.
// The row of cells keeps pairs sorted by key, so rank select reads one slot.
// A new operation is taken while the previous result waits in the output
// register; the apply step holds until that register is free.
// Reset (rst_n, synchronous, active low) clears the fill count and control only.
module fixed_capacity_key_value_table_unit
  import fkvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fkvt_in_if.sink    in_ch,
  fkvt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t                state_r;
  logic [KIND_BITS-1:0]  op_kind_r;
  logic [KEY_BITS-1:0]   op_key_r;
  logic [VALUE_BITS-1:0] op_val_r;
  logic [RANK_BITS-1:0]  op_rank_r;
  logic [CNT_W-1:0]      count_r;
  cell_cmd_t             cmd_r;
  logic                  res_ok_r;
  logic [KEY_BITS-1:0]   res_key_r;
  logic [VALUE_BITS-1:0] res_val_r;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [KEY_BITS-1:0]   out_key_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [CNT_W-1:0]      out_cnt_r;

  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   gt_vec;
  logic [CAPACITY-1:0]   eq_vec;

  logic                  in_xfer;
  logic                  finish;
  cell_cmd_t             cell_cmd;
  logic [CNT_W-1:0]      count_nxt;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cell_cmd = finish ? cmd_r : cell_cmd_t'('0);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                  p_gt;
      logic [KEY_BITS-1:0]   p_key;
      logic [VALUE_BITS-1:0] p_val;
      logic [KEY_BITS-1:0]   n_key;
      logic [VALUE_BITS-1:0] n_val;

      if (gi == 0) begin : g_first
        assign p_gt  = 1'b0;
        assign p_key = '0;
        assign p_val = '0;
      end else begin : g_mid
        assign p_gt  = gt_vec[gi-1];
        assign p_key = cell_key[gi-1];
        assign p_val = cell_val[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign n_key = cell_key[gi];
        assign n_val = cell_val[gi];
      end else begin : g_inner
        assign n_key = cell_key[gi+1];
        assign n_val = cell_val[gi+1];
      end

      fkvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk        (clk),
        .cmp_en     (state_r == ST_CMP),
        .occupied   (CNT_W'(gi) < count_r),
        .cmp_key    (op_key_r),
        .cmd        (cell_cmd),
        .new_value  (op_val_r),
        .prev_gt    (p_gt),
        .prev_key   (p_key),
        .prev_value (p_val),
        .next_key   (n_key),
        .next_value (n_val),
        .key        (cell_key[gi]),
        .value      (cell_val[gi]),
        .gt         (gt_vec[gi]),
        .eq         (eq_vec[gi])
      );
    end
  endgenerate

  // Decide step: match, fullness, selected pair.
  logic                  hit;
  logic                  full;
  logic                  rank_ok;
  logic [KEY_BITS-1:0]   rank_key;
  logic [VALUE_BITS-1:0] rank_val;
  logic [VALUE_BITS-1:0] hit_val;
  cell_cmd_t             dec_cmd;
  logic                  dec_ok;
  logic [KEY_BITS-1:0]   dec_key;
  logic [VALUE_BITS-1:0] dec_val;

  assign hit     = |eq_vec;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign rank_ok = int'(op_rank_r) < int'(count_r);

  always_comb begin
    rank_key = '0;
    rank_val = '0;
    hit_val  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (int'(op_rank_r) == i) begin
        rank_key = rank_key | cell_key[i];
        rank_val = rank_val | cell_val[i];
      end
      if (eq_vec[i]) begin
        hit_val = hit_val | cell_val[i];
      end
    end
  end

  always_comb begin
    dec_cmd = '0;
    dec_ok  = 1'b0;
    dec_key = '0;
    dec_val = '0;
    unique case (op_kind_r)
      KIND_INSERT: begin
        dec_cmd.ins = !hit && !full;
        dec_ok      = !hit && !full;
      end
      KIND_UPDATE: begin
        dec_cmd.upd = hit;
        dec_ok      = hit;
      end
      KIND_UPSERT: begin
        dec_cmd.upd = hit;
        dec_cmd.ins = !hit && !full;
        dec_ok      = hit || !full;
      end
      KIND_ERASE: begin
        dec_cmd.ers = hit;
        dec_ok      = hit;
      end
      KIND_LOOKUP: begin
        dec_ok  = hit;
        dec_val = hit_val;
      end
      KIND_RANK: begin
        dec_ok = rank_ok;
        if (rank_ok) begin
          dec_key = rank_key;
          dec_val = rank_val;
        end
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd_r.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd_r.ers) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, else drop the one just transferred.
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (finish) begin
            count_r <= count_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_kind_r <= in_ch.kind;
      op_key_r  <= in_ch.key;
      op_val_r  <= in_ch.new_value;
      op_rank_r <= in_ch.rank_index;
    end
    if (state_r == ST_DEC) begin
      cmd_r     <= dec_cmd;
      res_ok_r  <= dec_ok;
      res_key_r <= dec_key;
      res_val_r <= dec_val;
    end
    if (finish) begin
      out_ok_r  <= res_ok_r;
      out_key_r <= res_key_r;
      out_val_r <= res_val_r;
      out_cnt_r <= count_nxt;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.value_out   = out_val_r;
  assign out_ch.entry_count = COUNT_BITS'(out_cnt_r);
  assign out_ch.is_empty    = (out_cnt_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> ($countones(eq_vec) <= 1))
    else $error("more than one cell matches the key");

  a_sorted_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> (((gt_vec << 1) & ~gt_vec) == '0))
    else $error("greater-than flags not monotone along the row");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && cmd_r.ins) |-> (count_r < CNT_W'(CAPACITY)))
    else $error("insert into a full table");

endmodule

### sim/tb_fixed_capacity_key_value_table_unit.sv
// Testbench for fixed_capacity_key_value_table_unit: directed and random table operations,
// each result checked against an in-bench table predictor under several idle patterns.
// Depends on fkvt_pkg, fkvt_in_if, fkvt_out_if and the unit itself.
module tb_fixed_capacity_key_value_table_unit
  import fkvt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = CAPACITY_DEF;
  localparam int KW         = KEY_BITS_DEF;
  localparam int VW         = VALUE_BITS_DEF;
  localparam int STALL_MAX  = 3000;
  localparam int TAIL_WAIT  = 16;
  localparam int SHOW_MAX   = 10;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [KW-1:0]        key;
    logic [VW-1:0]        value;
    logic [RANK_BITS-1:0] rank;
  } table_op_t;

  typedef struct packed {
    logic                  ok;
    logic [KW-1:0]         key;
    logic [VW-1:0]         value;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } table_reply_t;

  logic clk;
  logic rst_n;

  fkvt_in_if  in_ch ();
  fkvt_out_if out_ch ();

  fixed_capacity_key_value_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted table contents: unordered slots 0 .. table_fill-1.
  logic [KW-1:0] table_keys [SLOTS];
  logic [VW-1:0] table_vals [SLOTS];
  int            table_fill;

  table_reply_t replies_due [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int n_ops;
  int n_replies;
  int n_errors;
  int n_full_seen;
  int n_emptied;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int find_slot(logic [KW-1:0] k);
    for (int s = 0; s < table_fill; s++) begin
      if (table_keys[s] == k) return s;
    end
    return -1;
  endfunction

  // Apply one operation to the predicted table and return its reply.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    int           s;
    int           below;
    r = '0;
    s = find_slot(op.key);
    case (op.kind)
      KIND_INSERT, KIND_UPDATE, KIND_UPSERT: begin
        if (s >= 0 && op.kind != KIND_INSERT) begin
          table_vals[s] = op.value;
          r.ok = 1'b1;
        end else if (s < 0 && op.kind != KIND_UPDATE && table_fill < SLOTS) begin
          table_keys[table_fill] = op.key;
          table_vals[table_fill] = op.value;
          table_fill++;
          r.ok = 1'b1;
        end
      end
      KIND_ERASE: begin
        if (s >= 0) begin
          // move the last pair into the freed slot
          table_keys[s] = table_keys[table_fill-1];
          table_vals[s] = table_vals[table_fill-1];
          table_fill--;
          r.ok = 1'b1;
          if (table_fill == 0) n_emptied++;
        end
      end
      KIND_LOOKUP: begin
        if (s >= 0) begin
          r.value = table_vals[s];
          r.ok    = 1'b1;
        end
      end
      KIND_RANK: begin
        if (int'(op.rank) < table_fill) begin
          for (int j = 0; j < table_fill; j++) begin
            below = 0;
            for (int m = 0; m < table_fill; m++) begin
              if (table_keys[j] > table_keys[m]) below++;
            end
            if (below == int'(op.rank)) begin
              r.key   = table_keys[j];
              r.value = table_vals[j];
              r.ok    = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = table_fill[COUNT_BITS-1:0];
    r.empty = (table_fill == 0);
    if (table_fill == SLOTS) n_full_seen++;
    return r;
  endfunction

  // Drive one operation, hold it until the transfer, then record its reply.
  task automatic send_op(logic [KIND_BITS-1:0] kind, logic [KW-1:0] key,
                         logic [VW-1:0] value, logic [RANK_BITS-1:0] rank);
    table_op_t op;
    int        gap;
    op  = '{kind: kind, key: key, value: value, rank: rank};
    gap = 0;
    while (int'($urandom_range(99)) < sender_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op.kind;
    in_ch.key        <= op.key;
    in_ch.new_value  <= op.value;
    in_ch.rank_index <= op.rank;
    do @(posedge clk); while (!in_ch.ready);
    replies_due.push_back(apply_table_op(op));
    n_ops++;
  endtask

  // Hold off the sender until every outstanding reply has been checked.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(int sender_pct, int stall_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = stall_pct;
  endtask

  task automatic test_empty_table();
    send_op(KIND_LOOKUP, 32'h0000_0000, 32'h0, 6'd0);
    send_op(KIND_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_op(KIND_UPDATE, 32'h0000_0005, 32'h1234_5678, 6'd0);
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd0);
    send_op(KIND_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_insert_update();
    send_op(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_op(KIND_INSERT, 32'h0000_0000, 32'hAAAA_5555, 6'd0);
    send_op(KIND_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    send_op(KIND_UPSERT, 32'h0000_0000, 32'h5555_AAAA, 6'd0);
    send_op(KIND_UPSERT, 32'h8000_0000, 32'h0000_0001, 6'd0);
    send_op(KIND_LOOKUP, 32'h8000_0000, 32'h0, 6'd0);
    send_op(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0, 6'd0);
    send_op(KIND_SPARE_HI, 32'h0000_0000, 32'h0, 6'd0);
  endtask

  task automatic test_rank_select();
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd0);
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd1);
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd2);
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd3);
    send_op(KIND_RANK, 32'h0, 32'h0, 6'd63);
  endtask

  task automatic test_erase();
    send_op(KIND_ERASE, 32'h0000_0000, 32'h0, 6'd0);
    send_op(KIND_ERASE, 32'h0000_0000, 32'h0, 6'd0);
    send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_op(KIND_ERASE, 32'h8000_0000, 32'h0, 6'd0);
    send_op(KIND_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0);
  endtask

  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(3))
      0:       return KW'($urandom);
      1:       return KW'($urandom_range(15));
      2:       return {KW{1'b1}} - KW'($urandom_range(15));
      default: return KW'(1) << $urandom_range(KW-1);
    endcase
  endfunction

  // Random operations; grow_pct and shrink_pct steer the table toward full or empty.
  task automatic test_random_ops(int n, int grow_pct, int shrink_pct);
    logic [KIND_BITS-1:0] kind;
    logic [KW-1:0]        key;
    logic [RANK_BITS-1:0] rank;
    int                   pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 3)
        kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      else if (pick < 3 + grow_pct)
        kind = $urandom_range(1) ? KIND_INSERT : KIND_UPSERT;
      else if (pick < 3 + grow_pct + shrink_pct)
        kind = KIND_ERASE;
      else begin
        case ($urandom_range(2))
          0:       kind = KIND_UPDATE;
          1:       kind = KIND_LOOKUP;
          default: kind = KIND_RANK;
        endcase
      end
      if (table_fill > 0 && $urandom_range(99) < 60)
        key = table_keys[$urandom_range(table_fill - 1)];
      else
        key = pick_key();
      if (table_fill > 0 && $urandom_range(99) < 80)
        rank = RANK_BITS'($urandom_range(table_fill - 1));
      else
        rank = RANK_BITS'($urandom_range(63));
      send_op(kind, key, VW'($urandom), rank);
    end
  endtask

  // Result checker: compare each transfer with the oldest predicted reply.
  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{ok: out_ch.ok, key: out_ch.key_out, value: out_ch.value_out,
              count: out_ch.entry_count, empty: out_ch.is_empty};
      n_replies++;
      if (replies_due.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_MAX)
          $display("unexpected result: ok=%0b key=%h value=%h count=%0d empty=%0b",
                   got.ok, got.key, got.value, got.count, got.empty);
      end else begin
        want = replies_due.pop_front();
        if (got.ok !== want.ok || got.key !== want.key || got.value !== want.value ||
            got.count !== want.count || got.empty !== want.empty) begin
          n_errors++;
          if (n_errors <= SHOW_MAX)
            $display("mismatch at result %0d: exp ok=%0b key=%h value=%h count=%0d empty=%0b,",
                     n_replies, want.ok, want.key, want.value, want.count, want.empty,
                     " got ok=%0b key=%h value=%h count=%0d empty=%0b",
                     got.ok, got.key, got.value, got.count, got.empty);
        end
      end
    end
  end

  // Receiver: stall at random with the current percentage.
  initial begin
    forever begin
      @(negedge clk);
      out_ch.ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.key          = '0;
    in_ch.new_value    = '0;
    in_ch.rank_index   = '0;
    out_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    table_fill         = 0;
    n_ops              = 0;
    n_replies          = 0;
    n_errors           = 0;
    n_full_seen        = 0;
    n_emptied          = 0;
    quiet_cycles       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idle(0, 0);
    test_empty_table();
    test_insert_update();
    test_rank_select();
    test_erase();
    wait_drained();

    set_idle(0, 0);
    test_random_ops(235, 60, 10);
    test_random_ops(235, 15, 45);
    wait_drained();
    set_idle(85, 0);
    test_random_ops(235, 60, 10);
    test_random_ops(235, 15, 45);
    wait_drained();
    set_idle(0, 85);
    test_random_ops(235, 60, 10);
    test_random_ops(235, 15, 45);
    wait_drained();
    set_idle(11, 11);
    test_random_ops(235, 60, 10);
    test_random_ops(235, 15, 45);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("%0d operations sent, %0d results checked, %0d errors", n_ops, n_replies,
             n_errors);
    $display("table reached capacity on %0d operations and emptied by erase %0d times",
             n_full_seen, n_emptied);
    if (n_errors == 0 && replies_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
